### sv/brf_pkg.sv
// Shared widths, command codes, controller states and control structs of the byte ring buffer.
package brf_pkg;

  localparam int DATA_W        = 8;
  localparam int CMD_W         = 3;
  localparam int GRANT_W       = 7;
  localparam int CNT_W         = 11;
  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;
  localparam int CAP_RESET     = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_SKIP  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_byte;
  } ctl_t;

  typedef struct packed {
    logic out_valid;
    logic burst_req;
    logic burst_last;
  } stat_t;

endpackage

### sv/brf_if.sv
// Request and result channel interfaces of the byte ring buffer.
interface brf_in_if import brf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DATA_W-1:0]  data_in;
  logic [GRANT_W-1:0] length;

  modport source (output valid, output cmd, output data_in, output length, input ready);
  modport sink   (input valid, input cmd, input data_in, input length, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic               data_valid;
  logic               last;
  logic [GRANT_W-1:0] granted;
  logic [CNT_W-1:0]   fill_level;
  logic [CNT_W-1:0]   free_space;

  modport source (output valid, output data_out, output data_valid, output last,
                  output granted, output fill_level, output free_space, input ready);
  modport sink   (input valid, input data_out, input data_valid, input last,
                  input granted, input fill_level, input free_space, output ready);
endinterface

### sv/brf_ctrl.sv
// Controller state machine: request acceptance and burst sequencing.
module brf_ctrl import brf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output ctl_t  ctl
);

  state_t state;
  state_t state_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    out_free      = !stat.out_valid || out_ready;
    state_next    = state;
    in_ready      = 1'b0;
    ctl.accept    = 1'b0;
    ctl.emit_byte = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = out_free;
        ctl.accept = in_valid && out_free;
        if (ctl.accept && stat.burst_req) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        ctl.emit_byte = out_free;
        if (out_free && stat.burst_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/brf_dpath.sv
// Datapath: byte store, ring pointers, fill count, capacity register and result register.
module brf_dpath import brf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  ctl_t               ctl,
  output stat_t              stat,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [DATA_W-1:0]  in_data,
  input  logic [GRANT_W-1:0] in_length,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [DATA_W-1:0]  data_out,
  output logic               data_valid,
  output logic               last,
  output logic [GRANT_W-1:0] granted,
  output logic [CNT_W-1:0]   fill_level,
  output logic [CNT_W-1:0]   free_space
);

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
  localparam int CAP_RST = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [CNT_W-1:0]   cap;
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  wr_ptr_next;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [ADDR_W-1:0]  rd_ptr_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [ADDR_W-1:0]  burst_ptr;
  logic [GRANT_W-1:0] remain;
  logic [GRANT_W-1:0] burst_grant;
  logic [GRANT_W-1:0] req_clip;
  logic [GRANT_W-1:0] n;
  logic [GRANT_W-1:0] grant_single;
  logic [CNT_W-1:0]   cap_wr;
  logic               push_we;
  logic               full;
  logic               emit_single;

  function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0]  p,
                                             input logic [GRANT_W-1:0] k,
                                             input logic [CNT_W-1:0]   c);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(k);
    if (sum >= SUM_W'(c)) begin
      sum = sum - SUM_W'(c);
    end
    return ADDR_W'(sum);
  endfunction

  always_comb begin
    req_clip = (in_length > GRANT_W'(MAX_BURST)) ? GRANT_W'(MAX_BURST) : in_length;
    n        = (CNT_W'(req_clip) < count) ? req_clip : GRANT_W'(count);
    full     = count >= cap;
    cap_wr   = (cfg_wdata == '0) ? CNT_W'(1) :
               (32'(cfg_wdata) > DEPTH) ? CNT_W'(DEPTH) : cfg_wdata;

    stat.out_valid  = out_valid;
    stat.burst_req  = ((in_cmd == CMD_POP) || (in_cmd == CMD_PEEK)) && (n != '0);
    stat.burst_last = remain == GRANT_W'(1);
  end

  always_comb begin
    emit_single  = ctl.accept && !stat.burst_req;
    wr_ptr_next  = wr_ptr;
    rd_ptr_next  = rd_ptr;
    count_next   = count;
    grant_single = '0;
    push_we      = 1'b0;
    if (ctl.accept) begin
      unique case (cmd_t'(in_cmd))
        CMD_PUSH: begin
          if (!full) begin
            push_we      = 1'b1;
            wr_ptr_next  = adv(wr_ptr, GRANT_W'(1), cap);
            count_next   = count + CNT_W'(1);
            grant_single = GRANT_W'(1);
          end
        end
        CMD_POP: begin
          rd_ptr_next = adv(rd_ptr, n, cap);
          count_next  = count - CNT_W'(n);
        end
        CMD_SKIP: begin
          rd_ptr_next  = adv(rd_ptr, n, cap);
          count_next   = count - CNT_W'(n);
          grant_single = n;
        end
        CMD_CLEAR: begin
          wr_ptr_next = '0;
          rd_ptr_next = '0;
          count_next  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CNT_W'(CAP_RST);
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap    <= cap_wr;
        wr_ptr <= '0;
        rd_ptr <= '0;
        count  <= '0;
      end else begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
        count  <= count_next;
      end
      if (ctl.accept && stat.burst_req) begin
        remain <= n;
      end else if (ctl.emit_byte) begin
        remain <= remain - GRANT_W'(1);
      end
      if (emit_single || ctl.emit_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[wr_ptr] <= in_data;
    end
    if (ctl.accept && stat.burst_req) begin
      burst_ptr   <= rd_ptr;
      burst_grant <= n;
    end else if (ctl.emit_byte) begin
      burst_ptr <= adv(burst_ptr, GRANT_W'(1), cap);
    end
    if (ctl.emit_byte) begin
      data_out   <= mem[burst_ptr];
      data_valid <= 1'b1;
      last       <= stat.burst_last;
      granted    <= burst_grant;
      fill_level <= count_next;
      free_space <= cap - count_next;
    end else if (emit_single) begin
      data_out   <= '0;
      data_valid <= 1'b0;
      last       <= 1'b1;
      granted    <= grant_single;
      fill_level <= count_next;
      free_space <= cap - count_next;
    end
  end

endmodule

### sv/byte_ring_fifo_burst.sv
// Top level of the byte ring buffer with burst pop, peek and skip.
// Push, skip, clear and unknown requests, and pop or peek with nothing granted, return one
// result each; pop and peek of n granted bytes hold the request channel from the accept cycle
// until the last byte is loaded, one byte per cycle while the result register is free, since
// the single read port of the byte store feeds the result register. A new request is taken in
// the cycle the previous result leaves the result register. Writing capacity empties the
// buffer at once; there is no clearing pass after reset, since the fill count keeps unwritten slots from being read.
module byte_ring_fifo_burst import brf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  brf_in_if.sink           in_chan,
  brf_out_if.source        out_chan
);

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  assign in_chan.ready = in_ready;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  brf_dpath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (in_chan.cmd),
    .in_data    (in_chan.data_in),
    .in_length  (in_chan.length),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .data_out   (out_chan.data_out),
    .data_valid (out_chan.data_valid),
    .last       (out_chan.last),
    .granted    (out_chan.granted),
    .fill_level (out_chan.fill_level),
    .free_space (out_chan.free_space)
  );

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ctl.emit_byte)
    else $error("request accepted during a burst");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.ready |-> !ctl.emit_byte && !ctl.accept)
    else $error("result register overwritten while stalled");

  a_empty_result_is_last: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.data_valid |-> out_chan.last)
    else $error("result without data is not marked last");

  a_grant_bound: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid |-> out_chan.granted <= GRANT_W'(MAX_BURST))
    else $error("granted count above burst limit");

endmodule

### dv/byte_ring_fifo_burst_tb.sv
// Self-checking testbench for the byte ring buffer: directed and random requests against a shadow ring.
module byte_ring_fifo_burst_tb;
  import brf_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               last;
    logic [GRANT_W-1:0] granted;
    logic [CNT_W-1:0]   fill_level;
    logic [CNT_W-1:0]   free_space;
  } ring_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  brf_in_if  req_chan ();
  brf_out_if res_chan ();

  byte_ring_fifo_burst i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  logic [DATA_W-1:0] ring_bytes [DEPTH_DEF];
  logic [CNT_W-1:0]  ring_cap;
  logic [CNT_W-1:0]  ring_count;
  logic [CNT_W-2:0]  ring_wr;
  logic [CNT_W-2:0]  ring_rd;
  ring_result_t      owed_results [$];
  int                errors = 0;
  bit                send_idle_on;
  bit                take_idle_on;
  int                hold_requests = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CNT_W-2:0] ring_wrap(logic [CNT_W-2:0] p, int unsigned n);
    int unsigned q;
    q = p + n;
    while (q >= ring_cap) q -= ring_cap;
    return q[CNT_W-2:0];
  endfunction

  function automatic void owe(logic [DATA_W-1:0] b, logic v, logic l, int unsigned g);
    ring_result_t r;
    r.data_out   = b;
    r.data_valid = v;
    r.last       = l;
    r.granted    = g[GRANT_W-1:0];
    r.fill_level = ring_count;
    r.free_space = ring_cap - ring_count;
    owed_results.push_back(r);
  endfunction

  function automatic void ring_apply(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                                     logic [GRANT_W-1:0] n);
    int unsigned      want;
    int unsigned      take;
    int unsigned      i;
    logic [CNT_W-2:0] p;
    want = (n > MAX_BURST_DEF) ? MAX_BURST_DEF : n;
    take = (want < ring_count) ? want : ring_count;
    case (c)
      CMD_PUSH: begin
        if (ring_count < ring_cap) begin
          ring_bytes[ring_wr] = d;
          ring_wr = ring_wrap(ring_wr, 1);
          ring_count++;
          owe('0, 1'b0, 1'b1, 1);
        end else begin
          owe('0, 1'b0, 1'b1, 0);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (take == 0) begin
          owe('0, 1'b0, 1'b1, 0);
        end else begin
          p = ring_rd;
          if (c == CMD_POP) begin
            ring_rd = ring_wrap(ring_rd, take);
            ring_count = ring_count - CNT_W'(take);
          end
          for (i = 0; i < take; i++) begin
            owe(ring_bytes[p], 1'b1, i == take - 1, take);
            p = ring_wrap(p, 1);
          end
        end
      end
      CMD_SKIP: begin
        ring_rd = ring_wrap(ring_rd, take);
        ring_count = ring_count - CNT_W'(take);
        owe('0, 1'b0, 1'b1, take);
      end
      CMD_CLEAR: begin
        ring_wr = '0;
        ring_rd = '0;
        ring_count = '0;
        owe('0, 1'b0, 1'b1, 0);
      end
      default: begin
        owe('0, 1'b0, 1'b1, 0);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && res_chan.valid && res_chan.ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing due, expected none, got data_out %0h", $time,
                 res_chan.data_out);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("data_out", CNT_W'(want.data_out), CNT_W'(res_chan.data_out));
        check_field("data_valid", CNT_W'(want.data_valid), CNT_W'(res_chan.data_valid));
        check_field("last", CNT_W'(want.last), CNT_W'(res_chan.last));
        check_field("granted", CNT_W'(want.granted), CNT_W'(res_chan.granted));
        check_field("fill_level", want.fill_level, res_chan.fill_level);
        check_field("free_space", want.free_space, res_chan.free_space);
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int          hold_served;
    hold_left = 0;
    hold_served = 0;
    res_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 200;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= !take_idle_on || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] d,
                              input logic [GRANT_W-1:0] n);
    while (send_idle_on && $urandom_range(99) < 38) begin
      req_chan.valid <= 1'b0;
      @(posedge clk);
    end
    req_chan.valid   <= 1'b1;
    req_chan.cmd     <= c;
    req_chan.data_in <= d;
    req_chan.length  <= n;
    do @(posedge clk); while (!req_chan.ready);
    ring_apply(c, d, n);
  endtask

  task automatic send_random_request();
    int unsigned        pick;
    logic [CMD_W-1:0]   c;
    logic [GRANT_W-1:0] n;
    pick = $urandom_range(99);
    if (pick < 45)      c = CMD_PUSH;
    else if (pick < 65) c = CMD_POP;
    else if (pick < 77) c = CMD_PEEK;
    else if (pick < 89) c = CMD_SKIP;
    else if (pick < 96) c = CMD_CLEAR;
    else                c = CMD_W'($urandom_range(7, 5));
    pick = $urandom_range(99);
    if (pick < 80)      n = GRANT_W'($urandom_range(8));
    else if (pick < 95) n = GRANT_W'($urandom_range(64));
    else                n = GRANT_W'($urandom_range(127));
    send_request(c, DATA_W'($urandom_range(255)), n);
  endtask

  task automatic drain_results();
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v == 0)              ring_cap = CNT_W'(1);
    else if (v > DEPTH_DEF)  ring_cap = CNT_W'(DEPTH_DEF);
    else                     ring_cap = v;
    ring_wr    = '0;
    ring_rd    = '0;
    ring_count = '0;
  endtask

  task automatic set_idling(input bit on);
    req_chan.valid <= 1'b0;
    @(negedge clk);
    send_idle_on = on;
    take_idle_on = on;
    @(posedge clk);
  endtask

  task automatic test_empty_requests();
    send_request(CMD_POP, 8'h00, 7'd3);
    send_request(CMD_PEEK, 8'hFF, 7'd0);
    send_request(CMD_SKIP, 8'h00, 7'd64);
    send_request(3'd5, 8'h12, 7'd1);
    send_request(3'd6, 8'hED, 7'd127);
    send_request(3'd7, 8'h00, 7'd0);
  endtask

  task automatic test_basic_bursts();
    send_request(CMD_PUSH, 8'h00, 7'd0);
    send_request(CMD_PUSH, 8'hFF, 7'd127);
    send_request(CMD_PUSH, 8'hA5, 7'd0);
    send_request(CMD_PUSH, 8'h5A, 7'd0);
    send_request(CMD_PUSH, 8'h7F, 7'd0);
    send_request(CMD_PEEK, 8'h00, 7'd0);
    send_request(CMD_PEEK, 8'h00, 7'd127);
    send_request(CMD_POP, 8'h00, 7'd2);
    send_request(CMD_SKIP, 8'h00, 7'd1);
    send_request(CMD_POP, 8'h00, 7'd64);
    send_request(CMD_PUSH, 8'h3C, 7'd0);
    send_request(CMD_CLEAR, 8'h00, 7'd0);
    send_request(CMD_POP, 8'h00, 7'd1);
  endtask

  task automatic test_capacity_extremes();
    write_capacity('0);
    send_request(CMD_PUSH, 8'h11, 7'd0);
    send_request(CMD_PUSH, 8'h22, 7'd0);
    send_request(CMD_PEEK, 8'h00, 7'd1);
    send_request(CMD_POP, 8'h00, 7'd1);
    write_capacity('1);
    send_request(CMD_PUSH, 8'h33, 7'd0);
  endtask

  task automatic test_fill_and_clip();
    set_idling(1'b0);
    write_capacity(11'd70);
    repeat (75) send_request(CMD_PUSH, DATA_W'($urandom_range(255)),
                             GRANT_W'($urandom_range(127)));
    send_request(CMD_POP, 8'h00, 7'd127);
    send_request(CMD_PEEK, 8'h00, 7'd100);
    send_request(CMD_SKIP, 8'h00, 7'd127);
    repeat (30) send_request(CMD_PUSH, DATA_W'($urandom_range(255)), 7'd0);
    send_request(CMD_POP, 8'h00, 7'd64);
    set_idling(1'b1);
  endtask

  task automatic test_backpressure();
    write_capacity(11'd24);
    @(negedge clk);
    hold_requests++;
    @(posedge clk);
    repeat (40) send_random_request();
    drain_results();
  endtask

  task automatic test_random_traffic(input logic [CNT_W-1:0] cap, input int unsigned count);
    write_capacity(cap);
    repeat (count) send_random_request();
  endtask

  initial begin
    int unsigned wait_cycles;
    req_chan.valid   = 1'b0;
    req_chan.cmd     = '0;
    req_chan.data_in = '0;
    req_chan.length  = '0;
    send_idle_on     = 1'b1;
    take_idle_on     = 1'b1;
    ring_cap         = CNT_W'(CAP_RESET);
    ring_wr          = '0;
    ring_rd          = '0;
    ring_count       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_basic_bursts();
    test_capacity_extremes();
    test_fill_and_clip();
    test_backpressure();
    test_random_traffic(11'd5, 40);
    test_random_traffic(11'd1, 40);
    test_random_traffic(11'd1024, 40);
    test_random_traffic(11'd37, 40);
    test_random_traffic(CNT_W'($urandom_range(300, 2)), 40);
    test_random_traffic(11'd1500, 40);

    req_chan.valid <= 1'b0;
    wait_cycles = 0;
    while (owed_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none", $time,
               owed_results.size());
    end
    if (errors == 0 && owed_results.size() == 0) begin
      $display("byte_ring_fifo_burst_tb: done, clean");
    end else begin
      $display("byte_ring_fifo_burst_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("byte_ring_fifo_burst_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
sv/brf_pkg.sv
sv/brf_if.sv
sv/brf_ctrl.sv
sv/brf_dpath.sv
sv/byte_ring_fifo_burst.sv
dv/byte_ring_fifo_burst_tb.sv
